>>> src/spq_pkg.sv
// Package for the strict priority ready queue: sizes, codes and the
// controller-to-datapath command struct. No dependencies.
`default_nettype none
package spq_pkg;

  // Entries per priority level.
  localparam int LEVEL_DEPTH = 16;
  localparam int NUM_LEVELS  = 3;
  localparam int ENTRIES     = NUM_LEVELS * LEVEL_DEPTH;

  localparam int SLOT_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = $clog2(ENTRIES);

  localparam int ID_W  = 16;
  localparam int MEM_W = 16;
  localparam int PRI_W = 2;
  localparam int ST_W  = 2;
  localparam int ENTRY_W = ID_W + MEM_W;

  // Function codes.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Priority levels.
  localparam logic [PRI_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [PRI_W-1:0] LVL_MED  = 2'd1;
  localparam logic [PRI_W-1:0] LVL_HIGH = 2'd2;
  localparam logic [PRI_W-1:0] LVL_SAT  = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_ENQ   = 2'd0;
  localparam logic [ST_W-1:0] ST_DEQ   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic exec;      // accept an item and update the queue state
    logic load_out;  // move the finished result into the output register
  } cmd_t;

  // First memory address of a level.
  function automatic logic [ADDR_W-1:0] level_base(input logic [PRI_W-1:0] lvl);
    logic [ADDR_W-1:0] base;
    case (lvl)
      LVL_LOW:  base = '0;
      LVL_MED:  base = ADDR_W'(LEVEL_DEPTH);
      LVL_HIGH: base = ADDR_W'(2 * LEVEL_DEPTH);
      default:  base = ADDR_W'(2 * LEVEL_DEPTH);
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

>>> src/spq_ctrl.sv
// Controller of the strict priority ready queue: input handshake, the
// two-step item sequence and the output valid flag. Depends on spq_pkg.
`default_nettype none
module spq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output spq_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_FINISH = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_valid_r;
  assign cmd.exec     = in_tvalid && in_tready;
  // The result can only move out once the output register is free or draining.
  assign cmd.load_out = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (cmd.exec) state_nxt = S_FINISH;
      S_FINISH: if (cmd.load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/spq_dpath.sv
// Datapath of the strict priority ready queue: per-level head and count
// registers, the entry memory and the result register. Depends on spq_pkg.
`default_nettype none
module spq_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire spq_pkg::cmd_t             cmd,
  input  wire logic                      func,
  input  wire logic [spq_pkg::ID_W-1:0]  proc_id,
  input  wire logic [spq_pkg::PRI_W-1:0] priority_req,
  input  wire logic [spq_pkg::MEM_W-1:0] mem_size,
  output logic [spq_pkg::ST_W-1:0]       status,
  output logic [spq_pkg::ID_W-1:0]       out_id,
  output logic [spq_pkg::PRI_W-1:0]      out_priority,
  output logic [spq_pkg::MEM_W-1:0]      out_mem,
  output logic                           queue_empty
);

  logic [spq_pkg::SLOT_W-1:0] head_r [spq_pkg::NUM_LEVELS];
  logic [spq_pkg::CNT_W-1:0]  cnt_r  [spq_pkg::NUM_LEVELS];

  logic [spq_pkg::ENTRY_W-1:0] mem_r [spq_pkg::ENTRIES];
  logic [spq_pkg::ENTRY_W-1:0] rd_data_r;

  logic [spq_pkg::ST_W-1:0]  stat_r;
  logic [spq_pkg::PRI_W-1:0] lvl_r;

  logic [spq_pkg::ST_W-1:0]  status_r;
  logic [spq_pkg::ID_W-1:0]  out_id_r;
  logic [spq_pkg::PRI_W-1:0] out_priority_r;
  logic [spq_pkg::MEM_W-1:0] out_mem_r;
  logic                      queue_empty_r;

  logic [spq_pkg::ST_W-1:0]   stat_nxt;
  logic [spq_pkg::PRI_W-1:0]  lvl;
  logic [spq_pkg::SUM_W-1:0]  tail_sum;
  logic [spq_pkg::SLOT_W-1:0] slot;
  logic [spq_pkg::SLOT_W-1:0] head_inc;
  logic [spq_pkg::ADDR_W-1:0] addr;
  logic                       wr_en;
  logic                       pop;
  logic                       all_empty;

  assign all_empty = (cnt_r[0] == '0) && (cnt_r[1] == '0) && (cnt_r[2] == '0);

  always_comb begin
    lvl      = spq_pkg::LVL_LOW;
    stat_nxt = spq_pkg::ST_ENQ;
    wr_en    = 1'b0;
    pop      = 1'b0;
    tail_sum = '0;
    slot     = '0;
    if (func == spq_pkg::FUNC_ENQ) begin
      // The unused priority code saturates to the high level.
      lvl = (priority_req == spq_pkg::LVL_SAT) ? spq_pkg::LVL_HIGH : priority_req;
      tail_sum = spq_pkg::SUM_W'(head_r[lvl]) + spq_pkg::SUM_W'(cnt_r[lvl]);
      if (tail_sum >= spq_pkg::SUM_W'(spq_pkg::LEVEL_DEPTH)) begin
        tail_sum = tail_sum - spq_pkg::SUM_W'(spq_pkg::LEVEL_DEPTH);
      end
      slot = tail_sum[spq_pkg::SLOT_W-1:0];
      if (cnt_r[lvl] == spq_pkg::CNT_W'(spq_pkg::LEVEL_DEPTH)) begin
        stat_nxt = spq_pkg::ST_FULL;
      end else begin
        stat_nxt = spq_pkg::ST_ENQ;
        wr_en    = cmd.exec;
      end
    end else begin
      if (cnt_r[2] != '0) begin
        lvl = spq_pkg::LVL_HIGH;
      end else if (cnt_r[1] != '0) begin
        lvl = spq_pkg::LVL_MED;
      end else begin
        lvl = spq_pkg::LVL_LOW;
      end
      slot = head_r[lvl];
      if (all_empty) begin
        stat_nxt = spq_pkg::ST_EMPTY;
      end else begin
        stat_nxt = spq_pkg::ST_DEQ;
        pop      = cmd.exec;
      end
    end
    addr = spq_pkg::level_base(lvl) + spq_pkg::ADDR_W'(slot);
  end

  always_comb begin
    if (head_r[lvl] == spq_pkg::SLOT_W'(spq_pkg::LEVEL_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_r[lvl] + spq_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (wr_en) begin
      cnt_r[lvl] <= cnt_r[lvl] + spq_pkg::CNT_W'(1);
    end else if (pop) begin
      cnt_r[lvl]  <= cnt_r[lvl] - spq_pkg::CNT_W'(1);
      head_r[lvl] <= head_inc;
    end
  end

  // Entry memory: a write for each enqueue that is taken, and a registered read on every accepted item.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= {mem_size, proc_id};
    end
    if (cmd.exec) begin
      rd_data_r <= mem_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      stat_r <= stat_nxt;
      lvl_r  <= lvl;
    end
  end

  // Result register; the counts already reflect the item here.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r      <= stat_r;
      queue_empty_r <= all_empty;
      if (stat_r == spq_pkg::ST_DEQ) begin
        out_id_r       <= rd_data_r[spq_pkg::ID_W-1:0];
        out_mem_r      <= rd_data_r[spq_pkg::ENTRY_W-1:spq_pkg::ID_W];
        out_priority_r <= lvl_r;
      end else begin
        out_id_r       <= '0;
        out_mem_r      <= '0;
        out_priority_r <= '0;
      end
    end
  end

  assign status       = status_r;
  assign out_id       = out_id_r;
  assign out_priority = out_priority_r;
  assign out_mem      = out_mem_r;
  assign queue_empty  = queue_empty_r;

endmodule
`default_nettype wire

>>> src/strict_priority_ready_queue.sv
// Top level of the strict priority ready queue: stream ports, controller
// and datapath. Depends on spq_pkg, spq_ctrl and spq_dpath.
`default_nettype none
// Ready queue with three strict priority levels and one FIFO of
// spq_pkg::LEVEL_DEPTH entries per level. Each input transaction is an
// enqueue or a dequeue and yields exactly one result transaction. An item
// goes through the cycle of acceptance, in which the level registers
// are updated and the entry memory is written or read, and then the finish
// step, in which the registered memory read data is moved into the output
// register once that register is free or draining. The controller holds
// the input off until the result has moved into the output register, so a
// new item is not accepted before the last one is through. The output
// register holds a finished result while the next item is accepted. No
// clearing pass is needed after reset.
module strict_priority_ready_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] proc_id, [17:16] priority_req, [33:18] mem_size, [39:34] zero
  input  wire logic [39:0] in_tdata,
  // [0] func
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] out_id, [17:16] out_priority, [33:18] out_mem, [34] queue_empty,
  // [39:35] zero
  output logic [39:0]      out_tdata,
  // [1:0] status
  output logic [1:0]       out_tuser
);

  spq_pkg::cmd_t cmd;

  logic [spq_pkg::ST_W-1:0]  status;
  logic [spq_pkg::ID_W-1:0]  out_id;
  logic [spq_pkg::PRI_W-1:0] out_priority;
  logic [spq_pkg::MEM_W-1:0] out_mem;
  logic                      queue_empty;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .func         (in_tuser[0]),
    .proc_id      (in_tdata[15:0]),
    .priority_req (in_tdata[17:16]),
    .mem_size     (in_tdata[33:18]),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .out_mem      (out_mem),
    .queue_empty  (queue_empty)
  );

  assign out_tdata = {5'b0, queue_empty, out_mem, out_priority, out_id};
  assign out_tuser = status;

endmodule
`default_nettype wire
